// ===== hw/rtl/pcb_pkg.sv =====
// shared constants and payload types for the particle cell binning block
package pcb_pkg;

  localparam int MAX_CELLS     = 4096;
  localparam int MAX_PARTICLES = 65535;
  localparam int POS_FRAC_BITS = 16;
  localparam int INV_FRAC_BITS = 16;
  localparam int COORD_SHIFT   = POS_FRAC_BITS + INV_FRAC_BITS;

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int PART_AW = $clog2(MAX_PARTICLES + 1);
  localparam int CNT_W   = PART_AW + 1;

  // item kinds
  localparam logic [1:0] KIND_FRAME    = 2'd0;
  localparam logic [1:0] KIND_PARTICLE = 2'd1;
  localparam logic [1:0] KIND_HEAD     = 2'd2;
  localparam logic [1:0] KIND_LINK     = 2'd3;

  // configuration register indexes
  localparam int REG_ADDR_W = 3;
  localparam logic [REG_ADDR_W-1:0] REG_HALF_BOX_X = 3'd0;
  localparam logic [REG_ADDR_W-1:0] REG_HALF_BOX_Y = 3'd1;
  localparam logic [REG_ADDR_W-1:0] REG_HALF_BOX_Z = 3'd2;
  localparam logic [REG_ADDR_W-1:0] REG_INV_CELL_X = 3'd3;
  localparam logic [REG_ADDR_W-1:0] REG_INV_CELL_Y = 3'd4;
  localparam logic [REG_ADDR_W-1:0] REG_INV_CELL_Z = 3'd5;
  localparam logic [REG_ADDR_W-1:0] REG_GRID_DIMS  = 3'd6;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               deactivated;
    logic [15:0]        query_index;
  } item_t;

  typedef struct packed {
    logic [11:0] cell_index;
    logic [15:0] link_value;
    logic [15:0] particle_index;
    logic        binned;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic [REG_ADDR_W-1:0] addr;
    logic [31:0]           wdata;
  } cfg_t;

endpackage

// ===== hw/rtl/pcb_if.sv =====
// handshake channel interfaces for items, results and configuration writes
interface pcb_item_if;
  logic            valid;
  logic            ready;
  pcb_pkg::item_t  data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcb_result_if;
  logic             valid;
  logic             ready;
  pcb_pkg::result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pcb_cfg_if;
  logic          valid;
  logic          ready;
  pcb_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/particle_cell_binning.sv =====
// cell linked list binning: cell head memory, particle link memory and sequencer
// One item is worked on at a time; a result sits in an output register so the
// next item can be transferred while it waits. A particle that lands in a cell
// goes through the box test, the single 32x32 multiplier that steps through the
// three axes (multiply, then clamp), the two small index multiplies and the
// read-modify-write of the cell head memory. A deactivated particle goes straight
// to its result, one outside the box stops after the box test and one whose cell
// lies beyond the head memory skips the head write; an overflowing one goes
// straight to its result and a head or link read passes through a read state.
// After reset, and for every start-frame item, the block sweeps the 4096-entry
// cell head memory writing empty heads, one entry per cycle, and takes no item
// until the sweep ends; configuration writes are taken at any time.
module particle_cell_binning (
  input  logic                clk,
  input  logic                rst,
  pcb_item_if.sink            item,
  pcb_result_if.source        result,
  pcb_cfg_if.sink             cfg
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_OFF   = 4'd2;
  localparam logic [3:0] ST_MUL   = 4'd3;
  localparam logic [3:0] ST_CLAMP = 4'd4;
  localparam logic [3:0] ST_IDX1  = 4'd5;
  localparam logic [3:0] ST_IDX2  = 4'd6;
  localparam logic [3:0] ST_RD    = 4'd7;
  localparam logic [3:0] ST_WR    = 4'd8;
  localparam logic [3:0] ST_QRD   = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // configuration
  logic [30:0] half [3];
  logic [31:0] inv [3];
  logic [14:0] grid;

  // control
  logic [3:0]                   state;
  logic [pcb_pkg::CNT_W-1:0]    cnt;
  logic [pcb_pkg::CELL_AW-1:0]  clr_addr;
  logic                         clr_reply;
  logic                         out_valid;
  pcb_pkg::result_t             out_data;

  // per-item working registers
  logic [1:0]                   kind_q;
  logic                         qok;
  logic signed [31:0]           pos [3];
  logic [31:0]                  off [3];
  logic [1:0]                   axis;
  logic [31:0]                  prod_hi;
  logic [4:0]                   coord [3];
  logic [9:0]                   row_idx;
  logic [14:0]                  cell_idx;
  logic [pcb_pkg::PART_AW-1:0]  pidx;
  pcb_pkg::result_t             res;

  // memories
  logic [15:0] heads [pcb_pkg::MAX_CELLS];
  logic [15:0] links [pcb_pkg::MAX_PARTICLES + 1];
  logic [15:0] head_q;
  logic [15:0] link_q;

  logic                         head_we;
  logic [pcb_pkg::CELL_AW-1:0]  head_wa;
  logic [15:0]                  head_wd;
  logic [pcb_pkg::CELL_AW-1:0]  head_ra;

  logic signed [32:0] p_s [3];
  logic signed [32:0] h_s [3];
  logic signed [32:0] sum_s [3];
  logic [2:0]         inside_ax;
  logic [4:0]         dmax [3];
  logic [5:0]         ny;
  logic [5:0]         nz;
  logic [63:0]        prod;
  logic [10:0]        row_sum;
  logic [15:0]        lin_sum;
  logic               out_free;
  logic               item_xfer;

  assign item.ready   = (state == ST_IDLE);
  assign item_xfer    = item.valid && item.ready;
  assign cfg.ready    = 1'b1;
  assign result.valid = out_valid;
  assign result.data  = out_data;
  assign out_free     = !out_valid || result.ready;

  assign dmax[0] = grid[4:0];
  assign dmax[1] = grid[9:5];
  assign dmax[2] = grid[14:10];
  assign ny      = {1'b0, dmax[1]} + 6'd1;
  assign nz      = {1'b0, dmax[2]} + 6'd1;

  // box test and offset, all three axes side by side
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      p_s[a]       = {pos[a][31], pos[a]};
      h_s[a]       = {2'b00, half[a]};
      inside_ax[a] = (p_s[a] >= -h_s[a]) && (p_s[a] < h_s[a]);
      sum_s[a]     = p_s[a] + h_s[a];
    end
  end

  assign prod    = {32'd0, off[axis]} * {32'd0, inv[axis]};
  assign row_sum = 11'(coord[0]) * 11'(ny) + 11'(coord[1]);
  assign lin_sum = 16'(row_idx) * 16'(nz) + 16'(coord[2]);

  assign head_we = (state == ST_CLEAR) || (state == ST_WR);
  assign head_wa = (state == ST_CLEAR) ? clr_addr : cell_idx[pcb_pkg::CELL_AW-1:0];
  assign head_wd = (state == ST_CLEAR) ? 16'd0 : pidx;
  assign head_ra = (state == ST_RD) ? cell_idx[pcb_pkg::CELL_AW-1:0]
                                    : item.data.query_index[pcb_pkg::CELL_AW-1:0];

  always_ff @(posedge clk) begin
    if (head_we) begin
      heads[head_wa] <= head_wd;
    end
    head_q <= heads[head_ra];
  end

  always_ff @(posedge clk) begin
    if (state == ST_WR) begin
      links[pidx] <= head_q;
    end
    link_q <= links[item.data.query_index];
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      half <= '{default: '0};
      inv  <= '{default: '0};
      grid <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.data.addr)
        pcb_pkg::REG_HALF_BOX_X: half[0] <= cfg.data.wdata[30:0];
        pcb_pkg::REG_HALF_BOX_Y: half[1] <= cfg.data.wdata[30:0];
        pcb_pkg::REG_HALF_BOX_Z: half[2] <= cfg.data.wdata[30:0];
        pcb_pkg::REG_INV_CELL_X: inv[0]  <= cfg.data.wdata;
        pcb_pkg::REG_INV_CELL_Y: inv[1]  <= cfg.data.wdata;
        pcb_pkg::REG_INV_CELL_Z: inv[2]  <= cfg.data.wdata;
        pcb_pkg::REG_GRID_DIMS:  grid    <= cfg.data.wdata[14:0];
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= pcb_pkg::CNT_W'(1);
      clr_addr  <= '0;
      clr_reply <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // the output register reloads in the done state
      if (result.ready && (state != ST_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (item_xfer) begin
            kind_q <= item.data.kind;
            pos[0] <= item.data.pos_x;
            pos[1] <= item.data.pos_y;
            pos[2] <= item.data.pos_z;
            qok    <= (item.data.query_index < 16'(pcb_pkg::MAX_CELLS));
            unique case (item.data.kind)
              pcb_pkg::KIND_FRAME: begin
                res       <= '0;
                cnt       <= pcb_pkg::CNT_W'(1);
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= ST_CLEAR;
              end
              pcb_pkg::KIND_PARTICLE: begin
                if (cnt > pcb_pkg::CNT_W'(pcb_pkg::MAX_PARTICLES)) begin
                  // saturated: flag and drop
                  res   <= '{overflow: 1'b1, default: '0};
                  state <= ST_DONE;
                end else begin
                  pidx  <= cnt[pcb_pkg::PART_AW-1:0];
                  res   <= '{particle_index: 16'(cnt), default: '0};
                  cnt   <= cnt + pcb_pkg::CNT_W'(1);
                  state <= item.data.deactivated ? ST_DONE : ST_OFF;
                end
              end
              default: begin
                res   <= '0;
                state <= ST_QRD;
              end
            endcase
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == pcb_pkg::CELL_AW'(pcb_pkg::MAX_CELLS - 1)) begin
            state <= clr_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_OFF: begin
          for (int a = 0; a < 3; a++) begin
            off[a] <= sum_s[a][31:0];
          end
          axis  <= 2'd0;
          state <= (&inside_ax) ? ST_MUL : ST_DONE;
        end
        ST_MUL: begin
          prod_hi <= 32'(prod >> pcb_pkg::COORD_SHIFT);
          state   <= ST_CLAMP;
        end
        ST_CLAMP: begin
          coord[axis] <= (prod_hi > 32'(dmax[axis])) ? dmax[axis] : prod_hi[4:0];
          axis        <= axis + 2'd1;
          state       <= (axis == 2'd2) ? ST_IDX1 : ST_MUL;
        end
        ST_IDX1: begin
          row_idx <= row_sum[9:0];
          state   <= ST_IDX2;
        end
        ST_IDX2: begin
          cell_idx <= lin_sum[14:0];
          state    <= ST_RD;
        end
        ST_RD: begin
          // head read issued this cycle; a cell beyond capacity skips the write
          state <= (cell_idx < 15'(pcb_pkg::MAX_CELLS)) ? ST_WR : ST_DONE;
        end
        ST_WR: begin
          res.cell_index <= cell_idx[11:0];
          res.link_value <= head_q;
          res.binned     <= 1'b1;
          state          <= ST_DONE;
        end
        ST_QRD: begin
          if (kind_q == pcb_pkg::KIND_HEAD) begin
            res.link_value <= qok ? head_q : 16'd0;
          end else begin
            res.link_value <= link_q;
          end
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // the counter is one-based and saturates one past capacity
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (cnt != '0) && (cnt <= pcb_pkg::CNT_W'(pcb_pkg::MAX_PARTICLES + 1)))
    else $error("particle counter out of range");

  // a head is never overwritten with the empty marker by a particle
  a_wr_pidx: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR) |-> (pidx != '0))
    else $error("particle write with index zero");

  // within a frame the previous head always belongs to an earlier particle
  a_link_order: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.data.binned) |->
      (result.data.link_value < result.data.particle_index))
    else $error("stored link does not point to an earlier particle");

  // no item is taken while the head memory is being swept
  a_no_xfer_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !item.ready)
    else $error("item ready during head sweep");

  // a finished result is not lost when the output register is busy
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && !out_free) |=> (state == ST_DONE))
    else $error("result dropped while output busy");

endmodule

// ===== verif/particle_cell_binning_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the particle cell binning block with directed and random item traffic
module particle_cell_binning_tb;

  localparam int LIMIT_CYCLES  = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 68;
  localparam int ONE           = 65536;
  localparam int MAX_REPORTS   = 40;

  typedef enum int {CFG_FULL, CFG_DENSE, CFG_WIDE, CFG_MAX, CFG_FLAT, CFG_RANDOM} preset_t;
  typedef enum int {IDLE_ANY, IDLE_NONE, IDLE_LIGHT} idle_t;

  class bin_scoreboard_t;
    logic [30:0] half_box [3];
    logic [31:0] inv_cell [3];
    logic [14:0] grid_dims;
    logic [15:0] head_mem [pcb_pkg::MAX_CELLS];
    bit          head_set [pcb_pkg::MAX_CELLS];
    logic [15:0] link_mem [pcb_pkg::MAX_PARTICLES+1];
    bit          link_set [pcb_pkg::MAX_PARTICLES+1];
    int          linked_q [$];
    logic [16:0] next_idx;
    int          last_cell;
    pcb_pkg::result_t expected_q [$];
    int          errors;
    int          checked;
    int          binned_cnt;
    int          overflow_cnt;

    function new();
      half_box  = '{3{31'd0}};
      inv_cell  = '{3{32'd0}};
      grid_dims = '0;
      next_idx  = 17'd1;
      last_cell = 0;
    endfunction

    function void write_reg(logic [pcb_pkg::REG_ADDR_W-1:0] addr, logic [31:0] wdata);
      case (addr)
        pcb_pkg::REG_HALF_BOX_X: half_box[0] = wdata[30:0];
        pcb_pkg::REG_HALF_BOX_Y: half_box[1] = wdata[30:0];
        pcb_pkg::REG_HALF_BOX_Z: half_box[2] = wdata[30:0];
        pcb_pkg::REG_INV_CELL_X: inv_cell[0] = wdata;
        pcb_pkg::REG_INV_CELL_Y: inv_cell[1] = wdata;
        pcb_pkg::REG_INV_CELL_Z: inv_cell[2] = wdata;
        pcb_pkg::REG_GRID_DIMS:  grid_dims   = wdata[14:0];
        default: ;
      endcase
    endfunction

    // half-open box test, then floor((pos + half) * inv) clamped to the axis size
    function bit axis_coord(logic signed [31:0] pos, int axis, logic [4:0] dmax,
                            output int unsigned coord);
      longint      p;
      longint      hh;
      logic [63:0] off;
      logic [63:0] prod;
      logic [63:0] c64;
      p  = pos;
      hh = longint'(half_box[axis]);
      coord = 0;
      if (p < -hh || p >= hh) return 1'b0;
      off  = p + hh;
      prod = off * {32'd0, inv_cell[axis]};
      c64  = prod >> pcb_pkg::COORD_SHIFT;
      if (c64 > dmax) c64 = dmax;
      coord = c64[31:0];
      return 1'b1;
    endfunction

    function void note_item(pcb_pkg::item_t it);
      pcb_pkg::result_t r;
      int unsigned c [3];
      logic [4:0]  dmax [3];
      bit          ok;
      int unsigned idx;
      int unsigned pidx;
      logic [15:0] old;
      r = '0;
      case (it.kind)
        pcb_pkg::KIND_FRAME: begin
          foreach (head_set[i]) head_set[i] = 1'b0;
          next_idx = 17'd1;
        end
        pcb_pkg::KIND_PARTICLE: begin
          if (next_idx > pcb_pkg::MAX_PARTICLES) begin
            r.overflow = 1'b1;
            next_idx = 17'(pcb_pkg::MAX_PARTICLES + 1);
            overflow_cnt++;
          end else begin
            pidx = next_idx;
            r.particle_index = pidx[15:0];
            next_idx = next_idx + 17'd1;
            dmax[0] = grid_dims[4:0];
            dmax[1] = grid_dims[9:5];
            dmax[2] = grid_dims[14:10];
            ok = !it.deactivated;
            if (ok) ok = axis_coord(it.pos_x, 0, dmax[0], c[0]);
            if (ok) ok = axis_coord(it.pos_y, 1, dmax[1], c[1]);
            if (ok) ok = axis_coord(it.pos_z, 2, dmax[2], c[2]);
            if (ok) begin
              idx = (c[0] * (dmax[1] + 32'd1) + c[1]) * (dmax[2] + 32'd1) + c[2];
              // a cell index beyond the head memory drops the particle
              if (idx < pcb_pkg::MAX_CELLS) begin
                old = head_set[idx] ? head_mem[idx] : 16'd0;
                link_mem[pidx] = old;
                if (!link_set[pidx]) begin
                  link_set[pidx] = 1'b1;
                  linked_q = {linked_q, int'(pidx)};
                end
                head_mem[idx] = pidx[15:0];
                head_set[idx] = 1'b1;
                r.cell_index = idx[11:0];
                r.link_value = old;
                r.binned     = 1'b1;
                last_cell    = idx;
                binned_cnt++;
              end
            end
          end
        end
        pcb_pkg::KIND_HEAD: begin
          if (it.query_index < pcb_pkg::MAX_CELLS && head_set[it.query_index])
            r.link_value = head_mem[it.query_index];
        end
        default: begin
          r.link_value = link_mem[it.query_index];
        end
      endcase
      expected_q = {expected_q, r};
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(pcb_pkg::result_t got);
      pcb_pkg::result_t want;
      if (expected_q.size() == 0) begin
        report("result transfer with nothing outstanding");
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.cell_index !== want.cell_index)
        report($sformatf("result %0d cell_index %0h, wanted %0h",
                         checked, got.cell_index, want.cell_index));
      if (got.link_value !== want.link_value)
        report($sformatf("result %0d link_value %0h, wanted %0h",
                         checked, got.link_value, want.link_value));
      if (got.particle_index !== want.particle_index)
        report($sformatf("result %0d particle_index %0h, wanted %0h",
                         checked, got.particle_index, want.particle_index));
      if (got.binned !== want.binned)
        report($sformatf("result %0d binned %b, wanted %b", checked, got.binned, want.binned));
      if (got.overflow !== want.overflow)
        report($sformatf("result %0d overflow %b, wanted %b",
                         checked, got.overflow, want.overflow));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;

  pcb_item_if   item_ch ();
  pcb_result_if result_ch ();
  pcb_cfg_if    cfg_ch ();

  particle_cell_binning u_top (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  bin_scoreboard_t sb = new();
  idle_t         tx_mode = IDLE_ANY;
  idle_t         rx_mode = IDLE_ANY;
  int unsigned   cycle_cnt = 0;
  int            sent = 0;
  int            presets_done = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, sb.expected_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int draw_wait(idle_t mode);
    case (mode)
      IDLE_NONE:  return 0;
      IDLE_LIGHT: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 9)) : 0;
      default:    return $urandom_range(0, 9);
    endcase
  endfunction

  function automatic logic [31:0] box_pos(int axis);
    longint h;
    h = sb.half_box[axis];
    if (h == 0) return $urandom;
    return 32'(longint'($urandom) % (2 * h) - h);
  endfunction

  // values on, just inside and just past the box faces
  function automatic logic [31:0] face_pos(int axis);
    longint h;
    h = sb.half_box[axis];
    case ($urandom_range(0, 3))
      0:       return 32'(-h);
      1:       return 32'(h - 1);
      2:       return 32'(h);
      default: return 32'(-h - 1);
    endcase
  endfunction

  function automatic pcb_pkg::item_t rand_item(logic [1:0] kind);
    pcb_pkg::item_t it;
    it.kind        = kind;
    it.pos_x       = $urandom;
    it.pos_y       = $urandom;
    it.pos_z       = $urandom;
    it.deactivated = 1'($urandom_range(0, 1));
    it.query_index = 16'($urandom);
    return it;
  endfunction

  function automatic pcb_pkg::item_t at_pos(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                            bit off);
    pcb_pkg::item_t it;
    it = rand_item(pcb_pkg::KIND_PARTICLE);
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.deactivated = off;
    return it;
  endfunction

  function automatic pcb_pkg::item_t query(logic [1:0] kind, logic [15:0] q);
    pcb_pkg::item_t it;
    it = rand_item(kind);
    it.query_index = q;
    return it;
  endfunction

  function automatic pcb_pkg::item_t box_particle();
    return at_pos(box_pos(0), box_pos(1), box_pos(2), 1'b0);
  endfunction

  function automatic pcb_pkg::item_t next_random_item();
    pcb_pkg::item_t it;
    int    pick;
    int    axis;
    pick = $urandom_range(0, 99);
    if (pick < 2) return rand_item(pcb_pkg::KIND_FRAME);
    if (pick < 68) begin
      it = box_particle();
      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
        it = rand_item(pcb_pkg::KIND_PARTICLE);
      end else if (pick >= 88) begin
        axis = $urandom_range(0, 2);
        if (axis == 0) it.pos_x = face_pos(0);
        else if (axis == 1) it.pos_y = face_pos(1);
        else it.pos_z = face_pos(2);
      end else if (pick >= 80) begin
        it.deactivated = 1'b1;
      end
      return it;
    end
    if (pick < 84 || sb.linked_q.size() == 0) begin
      pick = $urandom_range(0, 3);
      if (pick < 2) return query(pcb_pkg::KIND_HEAD, 16'(sb.last_cell));
      if (pick == 2)
        return query(pcb_pkg::KIND_HEAD, 16'($urandom_range(0, pcb_pkg::MAX_CELLS - 1)));
      return rand_item(pcb_pkg::KIND_HEAD);
    end
    // only links that some binned particle has written are read back
    return query(pcb_pkg::KIND_LINK,
                 16'(sb.linked_q[$urandom_range(0, sb.linked_q.size() - 1)]));
  endfunction

  task automatic push_item(pcb_pkg::item_t it);
    int gap;
    gap = draw_wait(tx_mode);
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.data  = it;
    item_ch.valid = 1'b1;
    do @(posedge clk); while (item_ch.ready !== 1'b1);
    sb.note_item(it);
    sent++;
    @(negedge clk);
  endtask

  task automatic write_cfg(logic [pcb_pkg::REG_ADDR_W-1:0] addr, logic [31:0] wdata);
    pcb_pkg::cfg_t w;
    w.addr  = addr;
    w.wdata = wdata;
    cfg_ch.data  = w;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    sb.write_reg(addr, wdata);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic apply_preset(preset_t p);
    logic [31:0] hb [3];
    logic [31:0] ic [3];
    logic [14:0] dims;
    case (p)
      CFG_FULL: begin
        hb = '{3{32'(8 * ONE)}};
        ic = '{3{32'(ONE)}};
        dims = {5'd15, 5'd15, 5'd15};
      end
      CFG_DENSE: begin
        hb = '{3{32'(2 * ONE)}};
        ic = '{3{32'(ONE)}};
        dims = {5'd3, 5'd3, 5'd3};
      end
      CFG_WIDE: begin
        // twice as many cells as the head memory holds
        hb = '{3{32'(8 * ONE)}};
        ic = '{32'(2 * ONE), 32'(ONE), 32'(ONE)};
        dims = {5'd15, 5'd15, 5'd31};
      end
      CFG_MAX: begin
        hb = '{3{32'h7FFF_FFFF}};
        ic = '{3{32'hFFFF_FFFF}};
        dims = 15'h7FFF;
      end
      CFG_FLAT: begin
        hb = '{3{32'h7FFF_FFFF}};
        ic = '{3{32'd0}};
        dims = 15'd0;
      end
      default: begin
        foreach (hb[a]) begin
          hb[a] = ($urandom_range(1, 64) << 16) | $urandom_range(0, ONE - 1);
          ic[a] = $urandom_range(1 << 12, 1 << 18);
        end
        dims = 15'($urandom);
      end
    endcase
    // spare upper bits carry noise that the block must drop
    write_cfg(pcb_pkg::REG_HALF_BOX_X, {1'($urandom), hb[0][30:0]});
    write_cfg(pcb_pkg::REG_HALF_BOX_Y, {1'($urandom), hb[1][30:0]});
    write_cfg(pcb_pkg::REG_HALF_BOX_Z, {1'($urandom), hb[2][30:0]});
    write_cfg(pcb_pkg::REG_INV_CELL_X, ic[0]);
    write_cfg(pcb_pkg::REG_INV_CELL_Y, ic[1]);
    write_cfg(pcb_pkg::REG_INV_CELL_Z, ic[2]);
    write_cfg(pcb_pkg::REG_GRID_DIMS, {17'($urandom), dims});
    presets_done++;
  endtask

  task automatic settle();
    item_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic directed_items();
    // registers still at reset: the box is empty, so nothing is binned
    push_item(at_pos(32'd0, 32'd0, 32'd0, 1'b0));
    settle();
    apply_preset(CFG_FULL);
    push_item(rand_item(pcb_pkg::KIND_FRAME));
    push_item(at_pos(-8 * ONE, -8 * ONE, -8 * ONE, 1'b0));
    push_item(at_pos(-8 * ONE, -8 * ONE, -8 * ONE + ONE / 2, 1'b0));
    push_item(at_pos(8 * ONE - 1, 8 * ONE - 1, 8 * ONE - 1, 1'b0));
    push_item(at_pos(8 * ONE, 32'd0, 32'd0, 1'b0));
    push_item(at_pos(32'd0, -8 * ONE - 1, 32'd0, 1'b0));
    push_item(at_pos(32'd0, 32'd0, 32'h7FFF_FFFF, 1'b0));
    push_item(at_pos(32'h8000_0000, 32'd0, 32'd0, 1'b0));
    push_item(at_pos(32'd0, 32'd0, 32'd0, 1'b1));
    push_item(at_pos(32'd0, 32'd0, 32'd0, 1'b0));
    push_item(query(pcb_pkg::KIND_HEAD, 16'd0));
    push_item(query(pcb_pkg::KIND_HEAD, 16'(pcb_pkg::MAX_CELLS - 1)));
    push_item(query(pcb_pkg::KIND_HEAD, 16'(pcb_pkg::MAX_CELLS)));
    push_item(query(pcb_pkg::KIND_HEAD, 16'hFFFF));
    push_item(query(pcb_pkg::KIND_HEAD, 16'd5));
    push_item(query(pcb_pkg::KIND_LINK, 16'd2));
    push_item(query(pcb_pkg::KIND_LINK, 16'd1));
    push_item(rand_item(pcb_pkg::KIND_FRAME));
    push_item(query(pcb_pkg::KIND_HEAD, 16'd0));
    push_item(at_pos(-8 * ONE, -8 * ONE, -8 * ONE, 1'b0));
    push_item(query(pcb_pkg::KIND_LINK, 16'd1));
    settle();
  endtask

  initial begin
    int stall;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = draw_wait(rx_mode);
      if (stall > 0) begin
        result_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ch.ready = 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      sb.check_result(result_ch.data);
    end
  end

  initial begin
    rst           = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_items();
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      tx_mode = idle_t'(ph % 3);
      rx_mode = idle_t'((ph + 1) % 3);
      apply_preset(preset_t'(ph % 6));
      push_item(rand_item(pcb_pkg::KIND_FRAME));
      repeat (PHASE_ITEMS) push_item(next_random_item());
    end
    settle();

    $display("sent %0d items under %0d register settings, %0d results checked",
             sent, presets_done, sb.checked);
    $display("%0d particles binned, %0d refused on a full counter, %0d mismatches",
             sb.binned_cnt, sb.overflow_cnt, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
